// ----- hdl/ild_pkg.sv -----
`default_nettype none
package ild_pkg;

	localparam int CAPACITY_DEF   = 64;
	localparam int DATA_WIDTH_DEF = 32;

	localparam int CMD_W   = 4;
	localparam int INDEX_W = 32;
	localparam int VALUE_W = 32;
	localparam int DATA_W  = 32;
	localparam int STAT_W  = 2;
	localparam int COUNT_W = 7;

	localparam int IN_W  = 72;
	localparam int OUT_W = 48;

	localparam logic [CMD_W-1:0] CMD_PUSH    = 4'd0;
	localparam logic [CMD_W-1:0] CMD_UNSHIFT = 4'd1;
	localparam logic [CMD_W-1:0] CMD_POP     = 4'd2;
	localparam logic [CMD_W-1:0] CMD_SHIFT   = 4'd3;
	localparam logic [CMD_W-1:0] CMD_TOP     = 4'd4;
	localparam logic [CMD_W-1:0] CMD_BOTTOM  = 4'd5;
	localparam logic [CMD_W-1:0] CMD_GET     = 4'd6;
	localparam logic [CMD_W-1:0] CMD_SET     = 4'd7;
	localparam logic [CMD_W-1:0] CMD_EXISTS  = 4'd8;
	localparam logic [CMD_W-1:0] CMD_UNSET   = 4'd9;

	localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
	localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
	localparam logic [STAT_W-1:0] ST_RANGE = 2'd2;
	localparam logic [STAT_W-1:0] ST_FULL  = 2'd3;

	typedef struct packed {
		logic load;
		logic dec;
		logic link;
		logic take;
		logic walk;
		logic fin;
		logic give;
		logic post;
	} ctrl_cmd_t;

	typedef struct packed {
		logic is_push;
		logic is_pop;
		logic is_peek;
		logic is_idx;
		logic is_unset;
		logic full;
		logic empty;
		logic in_range;
		logic idx_zero;
		logic rem_last;
		logic out_free;
	} ctrl_sts_t;

endpackage
`default_nettype wire

// ----- hdl/ild_ram.sv -----
`default_nettype none
module ild_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

// ----- hdl/ild_ctrl.sv -----
`default_nettype none
module ild_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire ild_pkg::ctrl_sts_t sts,
	output ild_pkg::ctrl_cmd_t     cmd
);
	import ild_pkg::*;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_DEC  = 3'd1;
	localparam logic [2:0] S_LINK = 3'd2;
	localparam logic [2:0] S_TAKE = 3'd3;
	localparam logic [2:0] S_WALK = 3'd4;
	localparam logic [2:0] S_FIN  = 3'd5;
	localparam logic [2:0] S_GIVE = 3'd6;
	localparam logic [2:0] S_DONE = 3'd7;

	logic [2:0] state_q;
	logic [2:0] state_d;

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		state_d = state_q;
		cmd = '0;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d = S_DEC;
				end
			end
			S_DEC: begin
				cmd.dec = 1'b1;
				if (sts.is_push) begin
					state_d = sts.full ? S_DONE : S_LINK;
				end else if (sts.is_pop || sts.is_peek) begin
					state_d = sts.empty ? S_DONE : S_TAKE;
				end else if (sts.is_idx) begin
					if (!sts.in_range) begin
						state_d = S_DONE;
					end else if (sts.idx_zero) begin
						state_d = S_FIN;
					end else begin
						state_d = S_WALK;
					end
				end else begin
					state_d = S_DONE;
				end
			end
			S_LINK: begin
				cmd.link = 1'b1;
				state_d = S_DONE;
			end
			S_TAKE: begin
				cmd.take = 1'b1;
				state_d = S_DONE;
			end
			S_WALK: begin
				cmd.walk = 1'b1;
				if (sts.rem_last) begin
					state_d = S_FIN;
				end
			end
			S_FIN: begin
				cmd.fin = 1'b1;
				state_d = sts.is_unset ? S_GIVE : S_DONE;
			end
			S_GIVE: begin
				cmd.give = 1'b1;
				state_d = S_DONE;
			end
			S_DONE: begin
				if (sts.out_free) begin
					cmd.post = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

`ifndef SYNTH
	a_cmd_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(cmd))
		else $error("more than one datapath command at once");
	a_walk_exit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_WALK) && sts.rem_last |=> (state_q == S_FIN))
		else $error("walk did not end at the addressed element");
	a_post_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.post |=> in_ready)
		else $error("controller not idle after result");
`endif

endmodule
`default_nettype wire

// ----- hdl/ild_dpath.sv -----
`default_nettype none
module ild_dpath #(
	parameter int CAPACITY   = ild_pkg::CAPACITY_DEF,
	parameter int DATA_WIDTH = ild_pkg::DATA_WIDTH_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire ild_pkg::ctrl_cmd_t           cmd,
	output ild_pkg::ctrl_sts_t                sts,
	input  wire logic                         cfg_we,
	input  wire logic                         cfg_lifo,
	input  wire logic [ild_pkg::CMD_W-1:0]    in_cmd,
	input  wire logic [ild_pkg::INDEX_W-1:0]  in_index,
	input  wire logic [ild_pkg::VALUE_W-1:0]  in_value,
	output logic                              out_valid,
	input  wire logic                         out_ready,
	output logic      [ild_pkg::DATA_W-1:0]   out_data,
	output logic      [ild_pkg::STAT_W-1:0]   out_status,
	output logic                              out_exists,
	output logic      [ild_pkg::COUNT_W-1:0]  out_count,
	output logic                              out_empty
);
	import ild_pkg::*;

	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);

	logic [CMD_W-1:0]   cmd_q;
	logic [INDEX_W-1:0] idx_q;
	logic [VALUE_W-1:0] val_q;
	logic               lifo_q;
	logic [AW-1:0]      head_q, tail_q, free_q, cur_q;
	logic [CW-1:0]      cnt_q, rec_q, fresh_q, rem_q;
	logic [DATA_W-1:0]  data_q;
	logic [STAT_W-1:0]  st_q;
	logic               ex_q;

	logic [DATA_WIDTH-1:0] pay_rdata, pay_wdata;
	logic [AW-1:0]         nxt_rdata, prv_rdata;
	logic                  pay_we, nxt_we, prv_we;
	logic [AW-1:0]         pay_waddr, nxt_waddr, prv_waddr;
	logic [AW-1:0]         nxt_wdata, prv_wdata;
	logic [AW-1:0]         pay_raddr, link_raddr;

	logic [AW-1:0] end_slot, start_slot, new_slot, walk_next, sel_slot;
	logic          is_push, is_pop, is_peek, is_idx, in_range;
	logic [63:0]   val64, rd64;
	logic [31:0]   cnt32;

	assign is_push  = (cmd_q == CMD_PUSH) || (cmd_q == CMD_UNSHIFT);
	assign is_pop   = (cmd_q == CMD_POP) || (cmd_q == CMD_SHIFT);
	assign is_peek  = (cmd_q == CMD_TOP) || (cmd_q == CMD_BOTTOM);
	assign is_idx   = (cmd_q == CMD_GET) || (cmd_q == CMD_SET) || (cmd_q == CMD_UNSET);
	assign cnt32    = 32'(cnt_q);
	assign in_range = !idx_q[INDEX_W-1] && ({1'b0, idx_q[INDEX_W-2:0]} < cnt32);

	assign end_slot   = ((cmd_q == CMD_POP) || (cmd_q == CMD_TOP)) ? tail_q : head_q;
	assign start_slot = lifo_q ? tail_q : head_q;
	assign new_slot   = (rec_q != '0) ? free_q : fresh_q[AW-1:0];
	assign walk_next  = lifo_q ? prv_rdata : nxt_rdata;
	assign sel_slot   = is_push ? new_slot : (is_idx ? start_slot : end_slot);

	assign val64 = {32'd0, val_q};
	assign rd64  = 64'(pay_rdata);

	assign sts.is_push  = is_push;
	assign sts.is_pop   = is_pop;
	assign sts.is_peek  = is_peek;
	assign sts.is_idx   = is_idx;
	assign sts.is_unset = (cmd_q == CMD_UNSET);
	assign sts.full     = (cnt_q == CW'(CAPACITY));
	assign sts.empty    = (cnt_q == '0);
	assign sts.in_range = in_range;
	assign sts.idx_zero = (idx_q[INDEX_W-2:0] == '0);
	assign sts.rem_last = (rem_q == CW'(1));
	assign sts.out_free = !out_valid || out_ready;

	// read addresses
	always_comb begin
		pay_raddr  = cur_q;
		link_raddr = cur_q;
		if (cmd.dec) begin
			pay_raddr  = is_idx ? start_slot : end_slot;
			link_raddr = is_push ? free_q : (is_idx ? start_slot : end_slot);
		end else if (cmd.walk) begin
			pay_raddr  = walk_next;
			link_raddr = walk_next;
		end
	end

	// write ports
	always_comb begin
		pay_we    = 1'b0;
		pay_waddr = cur_q;
		pay_wdata = val64[DATA_WIDTH-1:0];
		nxt_we    = 1'b0;
		nxt_waddr = cur_q;
		nxt_wdata = free_q;
		prv_we    = 1'b0;
		prv_waddr = cur_q;
		prv_wdata = tail_q;
		if (cmd.link) begin
			pay_we = 1'b1;
			if (cnt_q != '0) begin
				nxt_we = 1'b1;
				prv_we = 1'b1;
				if (cmd_q == CMD_PUSH) begin
					nxt_waddr = tail_q;
					nxt_wdata = cur_q;
					prv_waddr = cur_q;
					prv_wdata = tail_q;
				end else begin
					nxt_waddr = cur_q;
					nxt_wdata = head_q;
					prv_waddr = head_q;
					prv_wdata = cur_q;
				end
			end
		end else if (cmd.take) begin
			nxt_we = is_pop;
		end else if (cmd.fin) begin
			if (cmd_q == CMD_SET) begin
				pay_we = 1'b1;
			end else if (cmd_q == CMD_UNSET) begin
				nxt_we    = (cur_q != head_q);
				nxt_waddr = prv_rdata;
				nxt_wdata = nxt_rdata;
				prv_we    = (cur_q != tail_q);
				prv_waddr = nxt_rdata;
				prv_wdata = prv_rdata;
			end
		end else if (cmd.give) begin
			nxt_we = 1'b1;
		end
	end

	ild_ram #(.WIDTH(DATA_WIDTH), .DEPTH(CAPACITY)) u_pay (
		.clk(clk), .we(pay_we), .waddr(pay_waddr), .wdata(pay_wdata),
		.raddr(pay_raddr), .rdata(pay_rdata)
	);

	ild_ram #(.WIDTH(AW), .DEPTH(CAPACITY)) u_nxt (
		.clk(clk), .we(nxt_we), .waddr(nxt_waddr), .wdata(nxt_wdata),
		.raddr(link_raddr), .rdata(nxt_rdata)
	);

	ild_ram #(.WIDTH(AW), .DEPTH(CAPACITY)) u_prv (
		.clk(clk), .we(prv_we), .waddr(prv_waddr), .wdata(prv_wdata),
		.raddr(link_raddr), .rdata(prv_rdata)
	);

	// item and walk registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cmd_q <= in_cmd;
			idx_q <= in_index;
			val_q <= in_value;
		end
		if (cmd.dec) begin
			cur_q  <= sel_slot;
			rem_q  <= idx_q[CW-1:0];
			data_q <= '0;
			ex_q   <= (cmd_q == CMD_GET) || (cmd_q == CMD_SET) ||
				(cmd_q == CMD_EXISTS) || (cmd_q == CMD_UNSET) ? in_range : 1'b0;
			if (is_push && sts.full) begin
				st_q <= ST_FULL;
			end else if ((is_pop || is_peek) && sts.empty) begin
				st_q <= ST_EMPTY;
			end else if (is_idx && !in_range) begin
				st_q <= ST_RANGE;
			end else begin
				st_q <= ST_OK;
			end
		end
		if (cmd.walk) begin
			cur_q <= walk_next;
			rem_q <= rem_q - CW'(1);
		end
		if (cmd.take || (cmd.fin && (cmd_q == CMD_GET))) begin
			data_q <= rd64[DATA_W-1:0];
		end
		if (cmd.post) begin
			out_data   <= data_q;
			out_status <= st_q;
			out_exists <= ex_q;
			out_count  <= cnt32[COUNT_W-1:0];
			out_empty  <= (cnt_q == '0);
		end
	end

	// list state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lifo_q    <= 1'b0;
			head_q    <= '0;
			tail_q    <= '0;
			free_q    <= '0;
			cnt_q     <= '0;
			rec_q     <= '0;
			fresh_q   <= '0;
			out_valid <= 1'b0;
		end else begin
			if (cfg_we) begin
				lifo_q <= cfg_lifo;
			end
			if (cmd.link) begin
				if (rec_q != '0) begin
					free_q <= nxt_rdata;
					rec_q  <= rec_q - CW'(1);
				end else begin
					fresh_q <= fresh_q + CW'(1);
				end
				if (cnt_q == '0) begin
					head_q <= cur_q;
					tail_q <= cur_q;
				end else if (cmd_q == CMD_PUSH) begin
					tail_q <= cur_q;
				end else begin
					head_q <= cur_q;
				end
				cnt_q <= cnt_q + CW'(1);
			end
			if (cmd.take && is_pop) begin
				if (cnt_q > CW'(1)) begin
					if (cmd_q == CMD_POP) begin
						tail_q <= prv_rdata;
					end else begin
						head_q <= nxt_rdata;
					end
				end
				cnt_q  <= cnt_q - CW'(1);
				free_q <= cur_q;
				rec_q  <= rec_q + CW'(1);
			end
			if (cmd.fin && (cmd_q == CMD_UNSET)) begin
				if (cur_q == head_q) begin
					head_q <= nxt_rdata;
				end
				if (cur_q == tail_q) begin
					tail_q <= prv_rdata;
				end
			end
			if (cmd.give) begin
				cnt_q  <= cnt_q - CW'(1);
				free_q <= cur_q;
				rec_q  <= rec_q + CW'(1);
			end
			if (cmd.post) begin
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

`ifndef SYNTH
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(CAPACITY))
		else $error("element count above capacity");
	a_pool_sum: assert property (@(posedge clk) disable iff (!arst_n)
		({1'b0, cnt_q} + {1'b0, rec_q}) == {1'b0, fresh_q})
		else $error("slot accounting broken");
	a_link_grow: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.link |=> (cnt_q == $past(cnt_q) + CW'(1)))
		else $error("insert did not grow the list");
`endif

endmodule
`default_nettype wire

// ----- hdl/indexed_linked_deque.sv -----
`default_nettype none
// Double-ended queue kept as a doubly linked list over a pool of CAPACITY
// slots in three single-port-write RAMs (payload, next and prev links).
// One item is worked on at a time. After the accept and decode, push and
// unshift link a new slot, pop, shift, top and bottom read an end slot, and
// exists and every error go straight to the result; get, set and unset walk
// to the addressed element one link per cycle through the link RAMs' read
// port, and unset then frees its slot. A new item is accepted from the cycle
// after the result is raised. The result sits in an output register, so the
// next item is taken while it waits. lifo_index is written through the cfg
// channel; the user must write it only while idle (not enforced by the block).
module indexed_linked_deque #(
	parameter int CAPACITY   = ild_pkg::CAPACITY_DEF,
	parameter int DATA_WIDTH = ild_pkg::DATA_WIDTH_DEF
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    s_tvalid,
	output logic                         s_tready,
	input  wire logic [ild_pkg::IN_W-1:0] s_tdata,  // cmd, index, value, zero pad
	output logic                         m_tvalid,
	input  wire logic                    m_tready,
	output logic      [ild_pkg::OUT_W-1:0] m_tdata, // data, status, exists, count, empty_res, pad
	input  wire logic                    cfg_valid,
	output logic                         cfg_ready,
	input  wire logic [0:0]              cfg_data   // lifo_index
);
	import ild_pkg::*;

	ctrl_cmd_t            cmd;
	ctrl_sts_t            sts;
	logic [DATA_W-1:0]    out_data;
	logic [STAT_W-1:0]    out_status;
	logic                 out_exists;
	logic [COUNT_W-1:0]   out_count;
	logic                 out_empty;

	assign cfg_ready = 1'b1;

	ild_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(s_tvalid), .in_ready(s_tready),
		.sts(sts), .cmd(cmd)
	);

	ild_dpath #(.CAPACITY(CAPACITY), .DATA_WIDTH(DATA_WIDTH)) u_dpath (
		.clk(clk), .arst_n(arst_n),
		.cmd(cmd), .sts(sts),
		.cfg_we(cfg_valid), .cfg_lifo(cfg_data[0]),
		.in_cmd(s_tdata[3:0]), .in_index(s_tdata[35:4]), .in_value(s_tdata[67:36]),
		.out_valid(m_tvalid), .out_ready(m_tready),
		.out_data(out_data), .out_status(out_status), .out_exists(out_exists),
		.out_count(out_count), .out_empty(out_empty)
	);

	assign m_tdata = {5'd0, out_empty, out_count, out_exists, out_status, out_data};

endmodule
`default_nettype wire

// ----- test/indexed_linked_deque_test.sv -----
`default_nettype none
module indexed_linked_deque_test;
	import ild_pkg::*;

	localparam int POOL = 64;
	localparam int IDLE_LIMIT = 20000;

	typedef struct packed {
		logic [31:0] data;
		logic [1:0]  status;
		logic        exists;
		logic [6:0]  count;
		logic        empty_res;
	} deque_result_t;

	// behavioral deque model plus the queue of results it predicts
	class deque_scoreboard;
		logic [31:0] payload[POOL];
		int unsigned nxt[POOL];
		int unsigned prv[POOL];
		int unsigned head, tail, count, free_head, free_count;
		bit lifo;
		deque_result_t pending[$];
		int mismatches;

		function void clear();
			for (int i = 0; i < POOL; i++) begin
				payload[i] = '0;
				prv[i] = 0;
				nxt[i] = (i + 1 < POOL) ? i + 1 : 0;
			end
			head = 0; tail = 0; count = 0; free_head = 0; free_count = POOL; lifo = 0;
			mismatches = 0;
		endfunction

		function int unsigned slot_at(int unsigned pos);
			int unsigned s;
			s = lifo ? tail : head;
			for (int unsigned i = 0; i < pos; i++)
				s = lifo ? prv[s] : nxt[s];
			return s;
		endfunction

		function void release_slot(int unsigned s);
			nxt[s] = free_head;
			free_head = s;
			free_count++;
		endfunction

		function void note_item(logic [3:0] cmd, logic [31:0] idx, logic [31:0] val);
			deque_result_t r;
			int unsigned s, p, n;
			bit in_range;
			r = '0;
			in_range = !idx[31] && (idx < count);
			if (cmd >= CMD_GET && cmd <= CMD_UNSET) r.exists = in_range;
			case (cmd)
				CMD_PUSH, CMD_UNSHIFT: begin
					if (free_count == 0) r.status = ST_FULL;
					else begin
						s = free_head;
						free_head = nxt[s];
						free_count--;
						payload[s] = val;
						if (count == 0) begin
							head = s; tail = s;
						end else if (cmd == CMD_PUSH) begin
							prv[s] = tail; nxt[tail] = s; tail = s;
						end else begin
							nxt[s] = head; prv[head] = s; head = s;
						end
						count++;
					end
				end
				CMD_POP, CMD_SHIFT: begin
					if (count == 0) r.status = ST_EMPTY;
					else begin
						s = (cmd == CMD_POP) ? tail : head;
						r.data = payload[s];
						if (count > 1) begin
							if (cmd == CMD_POP) tail = prv[s];
							else head = nxt[s];
						end
						count--;
						release_slot(s);
					end
				end
				CMD_TOP, CMD_BOTTOM: begin
					if (count == 0) r.status = ST_EMPTY;
					else r.data = payload[(cmd == CMD_TOP) ? tail : head];
				end
				CMD_GET, CMD_SET, CMD_UNSET: begin
					if (!in_range) r.status = ST_RANGE;
					else begin
						s = slot_at(idx);
						if (cmd == CMD_GET) r.data = payload[s];
						else if (cmd == CMD_SET) payload[s] = val;
						else begin
							p = prv[s]; n = nxt[s];
							if (s == head) head = n; else nxt[p] = n;
							if (s == tail) tail = p; else prv[n] = p;
							count--;
							release_slot(s);
						end
					end
				end
				default: ;
			endcase
			r.count = 7'(count);
			r.empty_res = (count == 0);
			pending.push_back(r);
		endfunction

		function void check_result(deque_result_t got);
			deque_result_t want;
			if (pending.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result %h", got);
				return;
			end
			want = pending.pop_front();
			if (got.data !== want.data || got.status !== want.status ||
				got.exists !== want.exists || got.count !== want.count ||
				got.empty_res !== want.empty_res) begin
				mismatches++;
				if (mismatches <= 10)
					$display("mismatch: expected data %h st %0d ex %0d cnt %0d emp %0d, got data %h st %0d ex %0d cnt %0d emp %0d",
						want.data, want.status, want.exists, want.count, want.empty_res,
						got.data, got.status, got.exists, got.count, got.empty_res);
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic s_tvalid;
	logic s_tready;
	logic [IN_W-1:0] s_tdata;
	logic m_tvalid;
	logic m_tready;
	logic [OUT_W-1:0] m_tdata;
	logic cfg_valid;
	logic cfg_ready;
	logic [0:0] cfg_data;

	deque_scoreboard sb;
	bit calm;
	int idle_cycles;

	indexed_linked_deque dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	initial begin
		clk = 0;
		forever #4 clk = ~clk;
	end

	function bit idle_now();
		return !calm && ($urandom_range(99) < 26);
	endfunction

	// result side: random stalls, check on every accepted result
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready)
				sb.check_result({m_tdata[31:0], m_tdata[33:32], m_tdata[34],
					m_tdata[41:35], m_tdata[42]});
			m_tready <= !idle_now();
		end
	end

	// watchdog on cycles without any accepted item
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else if (arst_n) begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles > IDLE_LIMIT) begin
				$display("Regression FAIL");
				$finish;
			end
		end
	end

	task automatic send_item(logic [3:0] cmd, logic [31:0] idx, logic [31:0] val);
		while (idle_now()) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= IN_W'({val, idx, cmd});
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		sb.note_item(cmd, idx, val);
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (150) @(posedge clk);
	endtask

	task automatic write_lifo(bit v);
		drain();
		cfg_valid <= 1'b1;
		cfg_data <= v;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		sb.lifo = v;
		cfg_valid <= 1'b0;
	endtask

	function logic [31:0] pick_index();
		case ($urandom_range(9))
			0: return $urandom;
			1: return 32'h8000_0000 | $urandom;
			2: return sb.count;
			3: return sb.count + $urandom_range(3);
			default: return (sb.count == 0) ? 0 : $urandom_range(sb.count - 1);
		endcase
	endfunction

	task automatic random_phase(int n);
		logic [3:0] cmd;
		int w;
		for (int i = 0; i < n; i++) begin
			calm = (i > n / 2 && i < n / 2 + 120);
			w = $urandom_range(99);
			if (w < 3) cmd = 4'(10 + $urandom_range(5));
			else if (w < 35) cmd = (sb.count > 56 && $urandom_range(1)) ? CMD_SHIFT :
				($urandom_range(1) ? CMD_PUSH : CMD_UNSHIFT);
			else if (w < 50) cmd = $urandom_range(1) ? CMD_POP : CMD_SHIFT;
			else if (w < 58) cmd = $urandom_range(1) ? CMD_TOP : CMD_BOTTOM;
			else cmd = 4'(CMD_GET + $urandom_range(3));
			send_item(cmd, pick_index(), $urandom);
		end
		calm = 0;
	endtask

	initial begin
		sb = new();
		sb.clear();
		calm = 0;
		idle_cycles = 0;
		arst_n = 0;
		s_tvalid = 0;
		s_tdata = '0;
		m_tready = 0;
		cfg_valid = 0;
		cfg_data = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty errors, extremes, every command
		send_item(CMD_POP, 0, 0);
		send_item(CMD_SHIFT, 0, 0);
		send_item(CMD_TOP, 0, 0);
		send_item(CMD_BOTTOM, 0, 0);
		send_item(CMD_GET, 0, 0);
		send_item(CMD_EXISTS, 32'h8000_0000, 0);
		send_item(CMD_PUSH, 0, 32'hFFFF_FFFF);
		send_item(CMD_UNSHIFT, 32'hFFFF_FFFF, 32'h0);
		send_item(CMD_PUSH, 0, 32'hA5A5_5A5A);
		send_item(CMD_GET, 2, 0);
		send_item(CMD_GET, 3, 0);
		send_item(CMD_SET, 1, 32'h1234_5678);
		send_item(CMD_EXISTS, 32'h7FFF_FFFF, 0);
		send_item(CMD_EXISTS, 32'hFFFF_FFFF, 0);
		send_item(CMD_UNSET, 1, 0);
		send_item(4'hF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_item(CMD_TOP, 0, 0);
		send_item(CMD_BOTTOM, 0, 0);
		send_item(CMD_POP, 0, 0);
		send_item(CMD_SHIFT, 0, 0);
		// fill past capacity for the full case
		for (int i = 0; i < POOL + 2; i++) send_item(CMD_PUSH, 0, $urandom);
		send_item(CMD_GET, 63, 0);
		send_item(CMD_UNSET, 63, 0);

		random_phase(500);
		write_lifo(1);
		random_phase(500);
		write_lifo(0);
		random_phase(400);
		write_lifo(1);
		random_phase(450);
		drain();

		if (sb.mismatches == 0 && sb.pending.size() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end
endmodule
`default_nettype wire
